### hw/rtl/assert_macros.svh
// Assertion macros shared by the tape machine RTL.
// No dependencies; included by the controller and the datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under synchronous active-low reset
`define TMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tape machine: implication check failed");

// Next-cycle implication under synchronous active-low reset
`define TMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tape machine: next-cycle check failed");

`endif

### hw/rtl/tms_pkg.sv
`timescale 1ns / 1ps
// Package for the tape machine: field widths, codes, payload and control types.
// No dependencies; used by every module of the block.
package tms_pkg;

    localparam int CMD_W       = 2;
    localparam int ADDR_W      = 12;
    localparam int OP_W        = 3;
    localparam int BYTE_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int PC_OUT_W    = 13;
    localparam int LEN_W       = 13;
    localparam int ORIGIN_W    = 12;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 1;

    localparam int PROG_DEPTH_DEF = 4096;
    localparam int TAPE_DEPTH_DEF = 4096;

    localparam logic [ORIGIN_W-1:0] ORIGIN_RESET = 12'd2048;

    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STEP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP     = 2'd3;

    localparam logic [OP_W-1:0] OP_INC   = 3'd0;
    localparam logic [OP_W-1:0] OP_DEC   = 3'd1;
    localparam logic [OP_W-1:0] OP_RIGHT = 3'd2;
    localparam logic [OP_W-1:0] OP_LEFT  = 3'd3;
    localparam logic [OP_W-1:0] OP_OUT   = 3'd4;
    localparam logic [OP_W-1:0] OP_IN    = 3'd5;
    localparam logic [OP_W-1:0] OP_OPEN  = 3'd6;
    localparam logic [OP_W-1:0] OP_CLOSE = 3'd7;

    localparam logic [STATUS_W-1:0] ST_RUN   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_END   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_JUMP  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_PROG_LEN    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAPE_ORIGIN = 1'd1;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] load_address;
        logic [OP_W-1:0]   load_op;
        logic [BYTE_W-1:0] in_byte;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                out_valid;
        logic [BYTE_W-1:0]   out_byte;
        logic                in_taken;
        logic [PC_OUT_W-1:0] program_counter;
        logic [OP_W-1:0]     executed_op;
    } t_out_item;

    typedef struct packed {
        logic take;
        logic clr_step;
        logic mod_step;
        logic exec;
        logic scan_f;
        logic scan_b;
        logic resp;
    } t_ctl_cmd;

    typedef struct packed {
        logic step_runs;
        logic clr_last;
        logic mod_last;
        logic go_fwd;
        logic go_back;
        logic scan_done;
        logic out_free;
    } t_dp_stat;

endpackage

### hw/rtl/tape_machine_step.sv
`timescale 1ns / 1ps
// Top level of the tape machine step engine: controller plus datapath.
// Depends on tms_pkg, tms_ctrl and tms_datapath.
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_ready    i_in  (t_in_item)
//   out      output     o_out_valid / i_out_ready  o_out (t_out_item)
//   cfg      input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// Load, no-op and halted step go from acceptance to the reply; plain step: fetch, execute, reply.
// Bracket jump: execute, then a scan of the program entries, then the reply.
// Restart: the one-cell-a-cycle tape clear sweep and the origin reduction, then the reply.
// After reset the clear sweep and the origin reduction run first,
// with o_in_ready low; configuration writes are taken throughout.
// A new transaction is taken while the previous result waits in the output register.
module tape_machine_step
    import tms_pkg::*;
#(
    parameter int PROG_DEPTH = PROG_DEPTH_DEF,
    parameter int TAPE_DEPTH = TAPE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_ctl_cmd ctl_cmd;
    t_dp_stat dp_stat;

    tms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_in.command),
        .i_stat     (dp_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (ctl_cmd)
    );

    tms_datapath #(
        .PROG_DEPTH (PROG_DEPTH),
        .TAPE_DEPTH (TAPE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctl_cmd),
        .o_stat      (dp_stat),
        .i_item      (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

### hw/rtl/tms_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the tape machine: sequences clear, origin reduce,
// execute, bracket scan and reply. Depends on tms_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tms_ctrl
    import tms_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_command,
    input  t_dp_stat         i_stat,
    output logic             o_in_ready,
    output t_ctl_cmd         o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_MOD   = 3'd1;
    localparam logic [2:0] S_IDLE  = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_SCANF = 3'd4;
    localparam logic [2:0] S_SCANB = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_reply;
    logic       n_reply;

    always_comb begin
        n_state    = r_state;
        n_reply    = r_reply;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_last) begin
                    n_state = r_reply ? S_RESP : S_IDLE;
                    n_reply = 1'b0;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    case (i_command)
                        CMD_STEP: begin
                            n_state = i_stat.step_runs ? S_EXEC : S_RESP;
                        end
                        CMD_RESTART: begin
                            n_state = S_CLEAR;
                            n_reply = 1'b1;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.go_fwd) begin
                    n_state = S_SCANF;
                end else if (i_stat.go_back) begin
                    n_state = S_SCANB;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_SCANF: begin
                o_cmd.scan_f = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_RESP;
                end
            end
            S_SCANB: begin
                o_cmd.scan_b = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.resp = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_reply <= 1'b0;
        end else begin
            r_state <= n_state;
            r_reply <= n_reply;
        end
    end

    `TMS_ASSERT_NXT(a_exec_not_idle, i_clk, i_rst_n, r_state == S_EXEC, r_state != S_IDLE)
    `TMS_ASSERT_NXT(a_scanf_exit, i_clk, i_rst_n, r_state == S_SCANF, (r_state == S_SCANF) || (r_state == S_RESP))
    `TMS_ASSERT_IMP(a_resp_slot_free, i_clk, i_rst_n, o_cmd.resp, i_stat.out_free)

endmodule

### hw/rtl/tms_datapath.sv
`timescale 1ns / 1ps
// Datapath of the tape machine: program and tape memories, counter, head,
// status, configuration registers, origin reduction and output register.
// Depends on tms_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tms_datapath
    import tms_pkg::*;
#(
    parameter int PROG_DEPTH = PROG_DEPTH_DEF,
    parameter int TAPE_DEPTH = TAPE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctl_cmd              i_cmd,
    output t_dp_stat              o_stat,
    input  t_in_item              i_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output t_out_item             o_out
);

    localparam int PA  = $clog2(PROG_DEPTH);
    localparam int PCW = $clog2(PROG_DEPTH + 1);
    localparam int HW  = $clog2(TAPE_DEPTH);
    localparam int LW  = (PCW > LEN_W) ? PCW : LEN_W;
    localparam int MCW = 1;
    localparam int MS  = ORIGIN_W + HW;
    localparam int MW  = ORIGIN_W + 2;
    localparam int PW  = ORIGIN_W + MW;
    localparam longint unsigned MREC =
        ((64'd1 << MS) + longint'(TAPE_DEPTH) - 64'd1) / longint'(TAPE_DEPTH);

    logic [OP_W-1:0]   r_prog_mem [PROG_DEPTH];
    logic [BYTE_W-1:0] r_tape_mem [TAPE_DEPTH];
    logic [OP_W-1:0]   r_prog_q;
    logic [BYTE_W-1:0] r_tape_q;

    logic [LEN_W-1:0]    r_prog_len;
    logic [ORIGIN_W-1:0] r_origin;
    logic [PCW-1:0]      r_pc;
    logic [STATUS_W-1:0] r_halt;
    logic [HW-1:0]       r_head;
    logic [PCW-1:0]      r_ptr;
    logic [PCW-1:0]      r_depth;
    logic [ORIGIN_W-1:0] r_num;
    logic [ORIGIN_W-1:0] r_quot;
    logic [MCW-1:0]      r_mod_cnt;
    logic [HW-1:0]       r_clr_addr;
    logic [BYTE_W-1:0]   r_in_byte;
    logic                r_ovalid;
    logic [BYTE_W-1:0]   r_obyte;
    logic                r_taken;
    logic [OP_W-1:0]     r_eop;
    logic                r_out_valid;
    t_out_item           r_out;

    logic [LW-1:0]       len_ext;
    logic [PCW-1:0]      len_act;
    logic [PCW-1:0]      pc_inc;
    logic [PCW-1:0]      n_ptr;
    logic                ld_ok;
    logic [PA-1:0]       ld_idx;
    logic [OP_W-1:0]     op;
    logic [BYTE_W-1:0]   cur_cell;
    logic                go_fwd;
    logic                go_back;
    logic                f_end;
    logic                f_hit;
    logic                b_hit;
    logic                b_end;
    logic [PW-1:0]       mod_prod;
    logic [ORIGIN_W-1:0] mod_quot;
    logic [PW-1:0]       mod_back;
    logic [PW-1:0]       mod_diff;
    logic [HW-1:0]       mod_rem;
    logic                tape_we;
    logic [HW-1:0]       tape_waddr;
    logic [BYTE_W-1:0]   tape_wdata;
    logic                restart_take;
    logic                halt_hold;

    always_comb begin
        len_ext  = LW'(r_prog_len);
        len_act  = (len_ext > LW'(PROG_DEPTH)) ? PCW'(PROG_DEPTH) : PCW'(r_prog_len);
        pc_inc   = r_pc + PCW'(1);
        ld_ok    = LW'(i_item.load_address) < LW'(PROG_DEPTH);
        ld_idx   = PA'(i_item.load_address);
        op       = r_prog_q;
        cur_cell = r_tape_q;
        go_fwd   = (op == OP_OPEN) && (cur_cell == '0);
        go_back  = (op == OP_CLOSE) && (cur_cell != '0) && (r_pc != '0);
        f_end    = r_ptr >= len_act;
        f_hit    = !f_end && (op == OP_CLOSE) && (r_depth == '0);
        b_hit    = (op == OP_OPEN) && (r_depth == '0);
        b_end    = !b_hit && (r_ptr == '0);
        // origin reduction: reciprocal quotient, then multiply back and subtract
        mod_prod = PW'(r_num) * PW'(MREC);
        mod_quot = ORIGIN_W'(mod_prod >> MS);
        mod_back = PW'(r_quot) * PW'(TAPE_DEPTH);
        mod_diff = PW'(r_num) - mod_back;
        mod_rem  = HW'(mod_diff);
        restart_take = i_cmd.take && (i_item.command == CMD_RESTART);
        halt_hold    = (r_halt != ST_RUN) && !restart_take;

        if (i_cmd.exec) begin
            n_ptr = go_fwd ? pc_inc : (r_pc - PCW'(1));
        end else if (i_cmd.scan_f) begin
            n_ptr = r_ptr + PCW'(1);
        end else if (i_cmd.scan_b) begin
            n_ptr = r_ptr - PCW'(1);
        end else begin
            n_ptr = r_pc;
        end

        tape_we    = i_cmd.clr_step ||
                     (i_cmd.exec && ((op == OP_INC) || (op == OP_DEC) || (op == OP_IN)));
        tape_waddr = i_cmd.clr_step ? r_clr_addr : r_head;
        if (i_cmd.clr_step) begin
            tape_wdata = '0;
        end else begin
            case (op)
                OP_INC:  tape_wdata = cur_cell + BYTE_W'(1);
                OP_DEC:  tape_wdata = cur_cell - BYTE_W'(1);
                default: tape_wdata = r_in_byte;
            endcase
        end

        o_stat.step_runs = (r_halt == ST_RUN) && (r_pc < len_act);
        o_stat.clr_last  = r_clr_addr == HW'(TAPE_DEPTH - 1);
        o_stat.mod_last  = r_mod_cnt == MCW'(1);
        o_stat.go_fwd    = go_fwd;
        o_stat.go_back   = go_back;
        o_stat.scan_done = i_cmd.scan_f ? (f_end || f_hit) : (b_hit || b_end);
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    // program store: one write port, registered read at the next pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && (i_item.command == CMD_LOAD) && ld_ok) begin
            r_prog_mem[ld_idx] <= i_item.load_op;
        end
        r_prog_q <= r_prog_mem[n_ptr[PA-1:0]];
    end

    // tape store: clear sweep or cell update, registered read at the head
    always_ff @(posedge i_clk) begin
        if (tape_we) begin
            r_tape_mem[tape_waddr] <= tape_wdata;
        end
        r_tape_q <= r_tape_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_len  <= '0;
            r_origin    <= ORIGIN_RESET;
            r_pc        <= '0;
            r_halt      <= ST_RUN;
            r_num       <= ORIGIN_RESET;
            r_quot      <= '0;
            r_mod_cnt   <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PROG_LEN:    r_prog_len <= i_cfg_data;
                    REG_TAPE_ORIGIN: r_origin   <= i_cfg_data[ORIGIN_W-1:0];
                    default:         r_prog_len <= r_prog_len;
                endcase
            end

            if (i_cmd.take) begin
                case (i_item.command)
                    CMD_RESTART: begin
                        r_pc   <= '0;
                        r_halt <= ST_RUN;
                        r_num  <= r_origin;
                    end
                    CMD_STEP: begin
                        if ((r_halt == ST_RUN) && (r_pc >= len_act)) begin
                            r_halt <= ST_END;
                        end
                    end
                    default: begin
                        r_halt <= r_halt;
                    end
                endcase
            end

            if (i_cmd.clr_step) begin
                r_clr_addr <= o_stat.clr_last ? '0 : r_clr_addr + HW'(1);
            end

            if (i_cmd.mod_step) begin
                r_quot    <= mod_quot;
                r_mod_cnt <= o_stat.mod_last ? '0 : r_mod_cnt + MCW'(1);
            end

            if (i_cmd.exec) begin
                case (op)
                    OP_RIGHT: begin
                        if (r_head == HW'(TAPE_DEPTH - 1)) begin
                            r_halt <= ST_RANGE;
                        end else begin
                            r_pc <= pc_inc;
                        end
                    end
                    OP_LEFT: begin
                        if (r_head == '0) begin
                            r_halt <= ST_RANGE;
                        end else begin
                            r_pc <= pc_inc;
                        end
                    end
                    OP_OPEN: begin
                        if (!go_fwd) begin
                            r_pc <= pc_inc;
                        end
                    end
                    OP_CLOSE: begin
                        if ((cur_cell != '0) && (r_pc == '0)) begin
                            r_halt <= ST_JUMP;
                        end else if (!go_back) begin
                            r_pc <= pc_inc;
                        end
                    end
                    default: begin
                        r_pc <= pc_inc;
                    end
                endcase
            end

            if (i_cmd.scan_f) begin
                if (f_end) begin
                    r_halt <= ST_JUMP;
                end else if (f_hit) begin
                    r_pc <= r_ptr + PCW'(1);
                end
            end

            if (i_cmd.scan_b) begin
                if (b_hit) begin
                    r_pc <= r_ptr + PCW'(1);
                end else if (b_end) begin
                    r_halt <= ST_JUMP;
                end
            end

            if (i_cmd.resp) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;

        if (i_cmd.take) begin
            r_in_byte <= i_item.in_byte;
            r_ovalid  <= 1'b0;
            r_obyte   <= '0;
            r_taken   <= 1'b0;
            r_eop     <= OP_INC;
        end

        if (i_cmd.mod_step && o_stat.mod_last) begin
            r_head <= mod_rem;
        end

        if (i_cmd.exec) begin
            r_eop   <= op;
            r_depth <= '0;
            case (op)
                OP_RIGHT: begin
                    if (r_head != HW'(TAPE_DEPTH - 1)) begin
                        r_head <= r_head + HW'(1);
                    end
                end
                OP_LEFT: begin
                    if (r_head != '0) begin
                        r_head <= r_head - HW'(1);
                    end
                end
                OP_OUT: begin
                    r_ovalid <= 1'b1;
                    r_obyte  <= cur_cell;
                end
                OP_IN: begin
                    r_taken <= 1'b1;
                end
                default: begin
                    r_taken <= r_taken;
                end
            endcase
        end

        if (i_cmd.scan_f) begin
            if (op == OP_CLOSE) begin
                r_depth <= r_depth - PCW'(1);
            end else if (op == OP_OPEN) begin
                r_depth <= r_depth + PCW'(1);
            end
        end

        if (i_cmd.scan_b) begin
            if (op == OP_OPEN) begin
                r_depth <= r_depth - PCW'(1);
            end else if (op == OP_CLOSE) begin
                r_depth <= r_depth + PCW'(1);
            end
        end

        if (i_cmd.resp) begin
            r_out.status          <= r_halt;
            r_out.out_valid       <= r_ovalid;
            r_out.out_byte        <= r_obyte;
            r_out.in_taken        <= r_taken;
            r_out.program_counter <= PC_OUT_W'(r_pc);
            r_out.executed_op     <= r_eop;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `TMS_ASSERT_NXT(a_halt_sticky, i_clk, i_rst_n, halt_hold, $stable(r_pc) && $stable(r_halt))

endmodule

### tb/tape_machine_step_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the tape machine step engine: directed programs
// and random program sessions, checked against an in-bench machine.
// Depends on tms_pkg and tape_machine_step.
module tape_machine_step_test;
    import tms_pkg::*;

    localparam int PROG_N = PROG_DEPTH_DEF;
    localparam int TAPE_N = TAPE_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1500;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    t_in_item  cmd_queue[$];
    t_out_item reply_queue[$];
    int        errors = 0;
    int        sent_items = 0;
    bit        calm = 1'b0;

    logic [OP_W-1:0]     prog_ops [PROG_N];
    logic [BYTE_W-1:0]   tape_cells [TAPE_N];
    int unsigned         step_pc;
    int unsigned         head_pos;
    int unsigned         len_reg;
    int unsigned         origin_reg;
    logic [STATUS_W-1:0] halt_code;

    tape_machine_step uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void clear_machine();
        for (int k = 0; k < TAPE_N; k++) tape_cells[k] = '0;
        head_pos = origin_reg % TAPE_N;
        step_pc = 0;
        halt_code = ST_RUN;
    endfunction

    function automatic t_out_item run_command(input t_in_item it);
        t_out_item         res;
        int unsigned       lim;
        int unsigned       nxt;
        int unsigned       pos;
        int unsigned       depth;
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] cur_cell;
        bit                found;
        res = '0;
        case (it.command)
            CMD_LOAD: prog_ops[it.load_address] = it.load_op;
            CMD_RESTART: clear_machine();
            CMD_STEP: if (halt_code == ST_RUN) begin
                lim = (len_reg > PROG_N) ? PROG_N : len_reg;
                if (step_pc >= lim) begin
                    halt_code = ST_END;
                end else begin
                    cur_cell = tape_cells[head_pos];
                    op = prog_ops[step_pc];
                    nxt = step_pc + 1;
                    res.executed_op = op;
                    case (op)
                        OP_INC: tape_cells[head_pos] = cur_cell + 1'b1;
                        OP_DEC: tape_cells[head_pos] = cur_cell - 1'b1;
                        OP_RIGHT: if (head_pos + 1 >= TAPE_N) halt_code = ST_RANGE;
                                  else head_pos = head_pos + 1;
                        OP_LEFT: if (head_pos == 0) halt_code = ST_RANGE;
                                 else head_pos = head_pos - 1;
                        OP_OUT: begin
                            res.out_valid = 1'b1;
                            res.out_byte = cur_cell;
                        end
                        OP_IN: begin
                            tape_cells[head_pos] = it.in_byte;
                            res.in_taken = 1'b1;
                        end
                        OP_OPEN: if (cur_cell == 0) begin
                            depth = 0;
                            found = 1'b0;
                            pos = step_pc + 1;
                            while (pos < lim && !found) begin
                                if (prog_ops[pos] == OP_CLOSE) begin
                                    if (depth == 0) found = 1'b1;
                                    else depth = depth - 1;
                                end else if (prog_ops[pos] == OP_OPEN) begin
                                    depth = depth + 1;
                                end
                                if (!found) pos = pos + 1;
                            end
                            if (found) nxt = pos + 1;
                            else halt_code = ST_JUMP;
                        end
                        OP_CLOSE: if (cur_cell != 0) begin
                            depth = 0;
                            found = 1'b0;
                            pos = step_pc;
                            while (pos > 0 && !found) begin
                                pos = pos - 1;
                                if (prog_ops[pos] == OP_OPEN) begin
                                    if (depth == 0) found = 1'b1;
                                    else depth = depth - 1;
                                end else if (prog_ops[pos] == OP_CLOSE) begin
                                    depth = depth + 1;
                                end
                            end
                            if (found) nxt = pos + 1;
                            else halt_code = ST_JUMP;
                        end
                        default: ;
                    endcase
                    if (halt_code == ST_RUN) step_pc = nxt;
                end
            end
            default: ;
        endcase
        res.status = halt_code;
        res.program_counter = step_pc[PC_OUT_W-1:0];
        return res;
    endfunction

    task automatic mismatch(input string what, input logic [15:0] want, input logic [15:0] got);
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endtask

    task automatic check_reply(input t_out_item got);
        t_out_item want;
        want = reply_queue.pop_front();
        if (got.status !== want.status)
            mismatch("status", 16'(want.status), 16'(got.status));
        if (got.out_valid !== want.out_valid)
            mismatch("out_valid", 16'(want.out_valid), 16'(got.out_valid));
        if (got.out_byte !== want.out_byte)
            mismatch("out_byte", 16'(want.out_byte), 16'(got.out_byte));
        if (got.in_taken !== want.in_taken)
            mismatch("in_taken", 16'(want.in_taken), 16'(got.in_taken));
        if (got.program_counter !== want.program_counter)
            mismatch("program_counter", 16'(want.program_counter), 16'(got.program_counter));
        if (got.executed_op !== want.executed_op)
            mismatch("executed_op", 16'(want.executed_op), 16'(got.executed_op));
    endtask

    // Driver: predict on acceptance, then present the next transaction or idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) reply_queue.push_back(run_command(i_in));
            if (!i_in_valid || o_in_ready) begin
                if (cmd_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 19)) begin
                    i_in <= cmd_queue.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (reply_queue.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, expected nothing, actual %h",
                         $time, o_out);
            end else begin
                check_reply(o_out);
            end
        end
        i_out_ready <= calm || ($urandom_range(0, 99) >= 19);
    end

    task automatic send(input logic [CMD_W-1:0] cmd, input int unsigned addr,
                        input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data);
        t_in_item it;
        it.command = cmd;
        it.load_address = addr[ADDR_W-1:0];
        it.load_op = op;
        it.in_byte = data;
        cmd_queue.push_back(it);
        sent_items++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        while (cmd_queue.size() != 0 || i_in_valid || reply_queue.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_PROG_LEN) len_reg = val;
        else origin_reg = val;
    endtask

    task automatic load_program(input int unsigned n, input bit balanced);
        int              depth;
        int              r;
        logic [OP_W-1:0] op;
        depth = 0;
        for (int unsigned a = 0; a < n; a++) begin
            r = $urandom_range(0, 99);
            if (!balanced) op = OP_W'($urandom_range(OP_INC, OP_CLOSE));
            else if (depth == n - a) op = OP_CLOSE;
            else if (r < 15 && depth + 1 < n - a) op = OP_OPEN;
            else if (r < 30 && depth > 0) op = OP_CLOSE;
            else op = OP_W'($urandom_range(OP_INC, OP_IN));
            if (op == OP_OPEN) depth++;
            else if (op == OP_CLOSE) depth--;
            send(CMD_LOAD, a, op, BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic random_tail(input int unsigned count);
        int r;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 86) send(CMD_STEP, $urandom_range(0, PROG_N - 1),
                             OP_W'($urandom_range(OP_INC, OP_CLOSE)),
                             BYTE_W'($urandom_range(0, 255)));
            else if (r < 93) send(CMD_LOAD, $urandom_range(0, PROG_N - 1),
                                  OP_W'($urandom_range(OP_INC, OP_CLOSE)),
                                  BYTE_W'($urandom_range(0, 255)));
            else if (r < 97) send(CMD_NOP, $urandom_range(0, PROG_N - 1),
                                  OP_W'($urandom_range(OP_INC, OP_CLOSE)),
                                  BYTE_W'($urandom_range(0, 255)));
            else send(CMD_RESTART, $urandom_range(0, PROG_N - 1),
                      OP_W'($urandom_range(OP_INC, OP_CLOSE)),
                      BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int unsigned n;
        int unsigned origin;
        int          session;
        len_reg = 0;
        origin_reg = ORIGIN_RESET;
        clear_machine();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty program ends at once; halted machine repeats its status
        write_reg(REG_PROG_LEN, 0);
        send(CMD_STEP, 0, OP_INC, 8'h00);
        send(CMD_NOP, PROG_N - 1, OP_CLOSE, 8'hFF);
        send(CMD_STEP, 0, OP_INC, 8'h00);
        settle();

        // nested skip, loop back, wraps, moves, then run off the right end
        write_reg(REG_PROG_LEN, 14);
        write_reg(REG_TAPE_ORIGIN, TAPE_N - 1);
        send(CMD_LOAD, 0, OP_OPEN, 8'h00);
        send(CMD_LOAD, 1, OP_OPEN, 8'h00);
        send(CMD_LOAD, 2, OP_CLOSE, 8'h00);
        send(CMD_LOAD, 3, OP_CLOSE, 8'h00);
        send(CMD_LOAD, 4, OP_IN, 8'h00);
        send(CMD_LOAD, 5, OP_OPEN, 8'h00);
        send(CMD_LOAD, 6, OP_DEC, 8'h00);
        send(CMD_LOAD, 7, OP_CLOSE, 8'h00);
        send(CMD_LOAD, 8, OP_DEC, 8'h00);
        send(CMD_LOAD, 9, OP_OUT, 8'h00);
        send(CMD_LOAD, 10, OP_INC, 8'h00);
        send(CMD_LOAD, 11, OP_LEFT, 8'h00);
        send(CMD_LOAD, 12, OP_RIGHT, 8'h00);
        send(CMD_LOAD, 13, OP_RIGHT, 8'h00);
        send(CMD_RESTART, 0, OP_INC, 8'h00);
        repeat (14) send(CMD_STEP, 0, OP_INC, 8'd2);
        settle();

        // length beyond the store, one loop pass, then run off the left end
        write_reg(REG_PROG_LEN, 8191);
        write_reg(REG_TAPE_ORIGIN, 0);
        send(CMD_LOAD, 0, OP_INC, 8'h00);
        send(CMD_LOAD, 1, OP_OPEN, 8'h00);
        send(CMD_LOAD, 2, OP_DEC, 8'h00);
        send(CMD_LOAD, 3, OP_CLOSE, 8'h00);
        send(CMD_LOAD, 4, OP_OUT, 8'h00);
        send(CMD_LOAD, 5, OP_LEFT, 8'h00);
        send(CMD_RESTART, 0, OP_INC, 8'h00);
        repeat (7) send(CMD_STEP, 0, OP_INC, 8'h00);

        session = 0;
        origin = ORIGIN_RESET;
        while (sent_items < RANDOM_ITEMS) begin
            session++;
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
            if (session == 1) origin = 0;
            else if (session == 2) origin = TAPE_N - 1;
            else origin = $urandom_range(0, TAPE_N - 1);
            settle();
            calm = (session >= 4 && session <= 6);
            write_reg(REG_PROG_LEN, n);
            if (session <= 2 || $urandom_range(0, 1)) write_reg(REG_TAPE_ORIGIN, origin);
            load_program(n, session != 1 && $urandom_range(0, 7) != 0);
            send(CMD_RESTART, 0, OP_INC, BYTE_W'($urandom_range(0, 255)));
            random_tail($urandom_range(20, 90));
        end

        settle();
        calm = 1'b0;
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
